// ----- rtl/ccfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ccfr_pkg
// Shared types, codes and the crc-16 byte update for the command frame
// receiver.
// ----------------------------------------------------------------------------
package ccfr_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0]  SYNC_BYTE_RESET = 8'd47;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_INIT        = 16'h0000;

    localparam int OUT_TDATA_W = 56;

    // result kind carried on tuser
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    // receive phase; also tags each queued item with its role in the frame
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_CMD     = 3'd1,
        PH_ADDR_HI = 3'd2,
        PH_ADDR_LO = 3'd3,
        PH_LEN     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CRC_HI  = 3'd6,
        PH_CRC_LO  = 3'd7
    } ccfr_phase_t;

    typedef struct packed {
        ccfr_phase_t cls;
        logic [7:0]  data;
        logic [7:0]  index;
    } ccfr_item_t;

    // msb-first crc-16 with polynomial 0x1021, one byte
    function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/ccfr_front.sv -----
// ----------------------------------------------------------------------------
// ccfr_front
// Byte parser: hunts for the sync byte, tracks the frame layout and tags
// each accepted byte with its role before it enters the queue.
// ----------------------------------------------------------------------------
module ccfr_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    output logic                q_valid,
    input  logic                q_ready,
    output ccfr_pkg::ccfr_item_t q_item
);

    ccfr_pkg::ccfr_phase_t phase_reg, phase_next;
    logic [7:0] sync_reg;
    logic [8:0] len_reg;
    logic [8:0] count_reg, count_next;
    logic [8:0] count_inc;
    logic       accept;

    assign accept    = s_tvalid && q_ready;
    assign count_inc = count_reg + 9'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg <= ccfr_pkg::SYNC_BYTE_RESET;
        end else if (cfg_wr_en) begin
            sync_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ccfr_pkg::PH_HUNT;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            count_reg <= count_next;
            if (phase_reg == ccfr_pkg::PH_LEN) begin
                len_reg <= (s_tdata == 8'd0) ? 9'd256 : {1'b0, s_tdata};
            end
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        case (phase_reg)
            ccfr_pkg::PH_HUNT: begin
                if (s_tdata == sync_reg) begin
                    phase_next = ccfr_pkg::PH_CMD;
                end
            end
            ccfr_pkg::PH_CMD:     phase_next = ccfr_pkg::PH_ADDR_HI;
            ccfr_pkg::PH_ADDR_HI: phase_next = ccfr_pkg::PH_ADDR_LO;
            ccfr_pkg::PH_ADDR_LO: phase_next = ccfr_pkg::PH_LEN;
            ccfr_pkg::PH_LEN: begin
                phase_next = ccfr_pkg::PH_PAYLOAD;
                count_next = 9'd0;
            end
            ccfr_pkg::PH_PAYLOAD: begin
                count_next = count_inc;
                if (count_inc >= len_reg) begin
                    phase_next = ccfr_pkg::PH_CRC_HI;
                end
            end
            ccfr_pkg::PH_CRC_HI:  phase_next = ccfr_pkg::PH_CRC_LO;
            ccfr_pkg::PH_CRC_LO:  phase_next = ccfr_pkg::PH_HUNT;
            default:              phase_next = ccfr_pkg::PH_HUNT;
        endcase
    end

    // outputs
    always_comb begin
        s_tready     = q_ready;
        q_valid      = s_tvalid;
        q_item.cls   = phase_reg;
        q_item.data  = s_tdata;
        q_item.index = count_reg[7:0];
    end

    payload_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == ccfr_pkg::PH_PAYLOAD) |-> (count_reg < len_reg))
        else $error("payload count reached length inside payload phase");

    sync_starts_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == ccfr_pkg::PH_HUNT && s_tdata == sync_reg)
        |=> (phase_reg == ccfr_pkg::PH_CMD))
        else $error("sync byte did not start a frame");

endmodule

// ----- rtl/ccfr_fifo.sv -----
// ----------------------------------------------------------------------------
// ccfr_fifo
// Small queue of tagged bytes between the parser and the frame back end.
// ----------------------------------------------------------------------------
module ccfr_fifo #(
    parameter int DEPTH = ccfr_pkg::QUEUE_DEPTH_DEFAULT  // power of two, >= 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  ccfr_pkg::ccfr_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output ccfr_pkg::ccfr_item_t rd_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ccfr_pkg::ccfr_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    count_tracks_pointers: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != CNT_W'(DEPTH))
        |-> (PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0]))
        else $error("queue count disagrees with pointers");

endmodule

// ----- rtl/ccfr_back.sv -----
// ----------------------------------------------------------------------------
// ccfr_back
// Frame back end: runs the crc, holds the header fields and builds the
// payload and frame-complete results in the output register.
// ----------------------------------------------------------------------------
module ccfr_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  ccfr_pkg::ccfr_item_t q_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ccfr_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  cmd_reg;
    logic [15:0] addr_reg;
    logic [8:0]  len_reg;
    logic [7:0]  crc_hi_reg;

    logic        valid_reg;
    logic        kind_reg;
    logic [7:0]  data_reg;
    logic [7:0]  index_reg;
    logic        ok_reg;

    logic        take;
    logic        emit;

    assign q_ready = !valid_reg || m_tready;
    assign take    = q_valid && q_ready;
    assign emit    = (q_item.cls == ccfr_pkg::PH_PAYLOAD)
                  || (q_item.cls == ccfr_pkg::PH_CRC_LO);

    // hunted bytes restart the crc from zero
    assign crc_next = ccfr_pkg::crc_fold(
        (q_item.cls == ccfr_pkg::PH_HUNT) ? ccfr_pkg::CRC_INIT : crc_reg, q_item.data);

    always_ff @(posedge aclk) begin
        if (take) begin
            case (q_item.cls)
                ccfr_pkg::PH_HUNT:    crc_reg <= crc_next;
                ccfr_pkg::PH_CMD: begin
                    crc_reg <= crc_next;
                    cmd_reg <= q_item.data;
                end
                ccfr_pkg::PH_ADDR_HI: begin
                    crc_reg        <= crc_next;
                    addr_reg[15:8] <= q_item.data;
                end
                ccfr_pkg::PH_ADDR_LO: begin
                    crc_reg       <= crc_next;
                    addr_reg[7:0] <= q_item.data;
                end
                ccfr_pkg::PH_LEN: begin
                    crc_reg <= crc_next;
                    len_reg <= (q_item.data == 8'd0) ? 9'd256 : {1'b0, q_item.data};
                end
                ccfr_pkg::PH_PAYLOAD: begin
                    crc_reg   <= crc_next;
                    kind_reg  <= ccfr_pkg::KIND_PAYLOAD;
                    data_reg  <= q_item.data;
                    index_reg <= q_item.index;
                    ok_reg    <= 1'b0;
                end
                ccfr_pkg::PH_CRC_HI:  crc_hi_reg <= q_item.data;
                ccfr_pkg::PH_CRC_LO: begin
                    kind_reg  <= ccfr_pkg::KIND_DONE;
                    data_reg  <= 8'd0;
                    index_reg <= 8'd0;
                    ok_reg    <= ({crc_hi_reg, q_item.data} == crc_reg);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_ready) begin
            valid_reg <= q_valid && emit;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = kind_reg;
    assign m_tdata  = {6'd0, ok_reg, index_reg, data_reg, len_reg, addr_reg, cmd_reg};

    payload_length_set: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (len_reg != 9'd0))
        else $error("result shown without a frame length");

    done_result_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && q_item.cls == ccfr_pkg::PH_CRC_LO)
        |=> (valid_reg && kind_reg == ccfr_pkg::KIND_DONE && data_reg == 8'd0))
        else $error("crc low byte did not produce a frame-complete result");

endmodule

// ----- rtl/crc_checked_command_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// crc_checked_command_frame_receiver
// Command frame receiver with crc-16 check, one byte per clock when not stalled.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle at full rate while the queue has room.
// A frame is sync byte, command, address high, address low, length (0
// means 256), payload, crc high, crc low; every payload byte gives one
// result (tuser 0) and the second crc byte gives one frame-complete result
// (tuser 1, tlast 1) with the crc match flag. Bytes pass the parser, a
// QUEUE_DEPTH-entry queue and the output register; s_tready drops only
// when the queue is full because the output side is stalled. The crc byte
// update is done combinationally in the back end. Write sync_byte only
// while the block is idle.
// ----------------------------------------------------------------------------
module crc_checked_command_frame_receiver #(
    parameter int QUEUE_DEPTH = ccfr_pkg::QUEUE_DEPTH_DEFAULT  // power of two, >= 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // sync_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] command, [23:8] address, [32:24] payload_length,
    // [40:33] data_byte, [48:41] byte_index, [49] crc_ok, [55:50] zero
    output logic [ccfr_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic        m_tuser,       // kind
    output logic        m_tlast        // last
);

    logic                 fq_valid, fq_ready;
    ccfr_pkg::ccfr_item_t fq_item;
    logic                 qb_valid, qb_ready;
    ccfr_pkg::ccfr_item_t qb_item;

    ccfr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_item      (fq_item)
    );

    ccfr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    ccfr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_item   (qb_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the crc-checked command frame receiver. A directed
// table covers field extremes, sync bytes inside a frame and both crc
// outcomes. Random frames, broken frames and line noise then run under
// several sync settings. Every accepted byte goes through an in-bench frame
// parser whose results are matched in order against the result stream.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_SETTLE     = 8;
    localparam int END_SETTLE      = 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTING_COUNT   = 5;
    localparam int BYTES_PER_SET   = 120;

    typedef struct packed {
        logic        kind;
        logic [7:0]  command;
        logic [15:0] address;
        logic [8:0]  payload_length;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic        crc_ok;
        logic        last;
        logic [5:0]  pad;
    } rx_result_t;

    // how a table row turns into a byte on the line
    typedef enum logic [2:0] {
        ROW_RAW,     // sent as is, not part of the crc
        ROW_SYNC,    // restarts the running frame crc
        ROW_FOLD,    // folded into the running frame crc
        ROW_CRC_HI,  // high byte of the running frame crc
        ROW_CRC_LO   // low byte of the running frame crc
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] value;
        logic       fixed_exp;
        logic       fixed_has;
        rx_result_t res;
    } dir_row_t;

    localparam rx_result_t NO_RES = '0;

    // frames at the reset sync byte; fixed_exp rows carry their expectation
    localparam dir_row_t DIRECTED_ROWS [20] = '{
        '{ROW_RAW,  8'h00, 1'b1, 1'b0, NO_RES},
        '{ROW_RAW,  8'hFF, 1'b1, 1'b0, NO_RES},
        '{ROW_RAW,  8'h2E, 1'b1, 1'b0, NO_RES},
        '{ROW_SYNC, 8'h2F, 1'b1, 1'b0, NO_RES},
        '{ROW_FOLD, 8'hFF, 1'b1, 1'b0, NO_RES},
        '{ROW_FOLD, 8'h00, 1'b1, 1'b0, NO_RES},
        '{ROW_FOLD, 8'hFF, 1'b1, 1'b0, NO_RES},
        '{ROW_FOLD, 8'h02, 1'b1, 1'b0, NO_RES},
        '{ROW_FOLD, 8'h00, 1'b1, 1'b1,
          '{1'b0, 8'hFF, 16'h00FF, 9'd2, 8'h00, 8'd0, 1'b0, 1'b0, 6'd0}},
        // sync value as payload is plain data
        '{ROW_FOLD, 8'h2F, 1'b1, 1'b1,
          '{1'b0, 8'hFF, 16'h00FF, 9'd2, 8'h2F, 8'd1, 1'b0, 1'b0, 6'd0}},
        '{ROW_RAW,  8'h00, 1'b1, 1'b0, NO_RES},
        '{ROW_RAW,  8'h00, 1'b0, 1'b0, NO_RES},
        '{ROW_SYNC, 8'h2F, 1'b1, 1'b0, NO_RES},
        '{ROW_FOLD, 8'h00, 1'b1, 1'b0, NO_RES},
        '{ROW_FOLD, 8'hFF, 1'b1, 1'b0, NO_RES},
        '{ROW_FOLD, 8'h00, 1'b1, 1'b0, NO_RES},
        '{ROW_FOLD, 8'h01, 1'b1, 1'b0, NO_RES},
        '{ROW_FOLD, 8'hFF, 1'b1, 1'b1,
          '{1'b0, 8'h00, 16'hFF00, 9'd1, 8'hFF, 8'd0, 1'b0, 1'b0, 6'd0}},
        '{ROW_CRC_HI, 8'h00, 1'b1, 1'b0, NO_RES},
        '{ROW_CRC_LO, 8'h00, 1'b0, 1'b0, NO_RES}
    };

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [7:0]             cfg_wr_data = 8'h00;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata     = 8'h00;  // [7:0] rx_byte
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    // [7:0] command, [23:8] address, [32:24] payload_length,
    // [40:33] data_byte, [48:41] byte_index, [49] crc_ok, [55:50] zero
    logic [ccfr_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;            // kind
    logic                   m_tlast;            // last

    // frame parser state
    logic [7:0]            sync_value;
    ccfr_pkg::ccfr_phase_t frame_phase;
    logic [15:0]           frame_crc;
    logic [7:0]            frame_cmd;
    logic [15:0]           frame_addr;
    logic [8:0]            frame_len;
    logic [8:0]            frame_count;
    logic [7:0]            crc_hi_byte;

    rx_result_t expected_q[$];
    int         error_count   = 0;
    int         bytes_accepted = 0;
    int         frame_bytes   = 0;
    int         burst_left    = 0;

    crc_checked_command_frame_receiver DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #5 aclk = ~aclk;

    // bitwise msb-first crc-16 update
    function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            c = {c[14:0], 1'b0} ^ ((c[15] ^ b[i]) ? ccfr_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic bit parse_rx_byte(input logic [7:0] b, output rx_result_t r);
        bit emitted;
        emitted = 1'b0;
        r = NO_RES;
        r.command = frame_cmd;
        case (frame_phase)
            ccfr_pkg::PH_HUNT: begin
                frame_crc = crc16_step(ccfr_pkg::CRC_INIT, b);
                if (b == sync_value) frame_phase = ccfr_pkg::PH_CMD;
            end
            ccfr_pkg::PH_CMD: begin
                frame_crc   = crc16_step(frame_crc, b);
                frame_cmd   = b;
                frame_phase = ccfr_pkg::PH_ADDR_HI;
            end
            ccfr_pkg::PH_ADDR_HI: begin
                frame_crc   = crc16_step(frame_crc, b);
                frame_addr  = {b, 8'h00};
                frame_phase = ccfr_pkg::PH_ADDR_LO;
            end
            ccfr_pkg::PH_ADDR_LO: begin
                frame_crc       = crc16_step(frame_crc, b);
                frame_addr[7:0] = b;
                frame_phase     = ccfr_pkg::PH_LEN;
            end
            ccfr_pkg::PH_LEN: begin
                frame_crc   = crc16_step(frame_crc, b);
                frame_len   = (b == 8'h00) ? 9'd256 : {1'b0, b};
                frame_count = 9'd0;
                frame_phase = ccfr_pkg::PH_PAYLOAD;
            end
            ccfr_pkg::PH_PAYLOAD: begin
                frame_crc = crc16_step(frame_crc, b);
                r.kind           = ccfr_pkg::KIND_PAYLOAD;
                r.command        = frame_cmd;
                r.address        = frame_addr;
                r.payload_length = frame_len;
                r.data_byte      = b;
                r.byte_index     = frame_count[7:0];
                emitted = 1'b1;
                frame_count = frame_count + 9'd1;
                if (frame_count >= frame_len) frame_phase = ccfr_pkg::PH_CRC_HI;
            end
            ccfr_pkg::PH_CRC_HI: begin
                crc_hi_byte = b;
                frame_phase = ccfr_pkg::PH_CRC_LO;
            end
            default: begin
                r.kind           = ccfr_pkg::KIND_DONE;
                r.command        = frame_cmd;
                r.address        = frame_addr;
                r.payload_length = frame_len;
                r.crc_ok         = ({crc_hi_byte, b} == frame_crc);
                r.last           = 1'b1;
                emitted = 1'b1;
                frame_phase = ccfr_pkg::PH_HUNT;
            end
        endcase
        return emitted;
    endfunction

    task automatic report_mismatch(input string what, input rx_result_t want,
                                   input rx_result_t got);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t %s: expected kind=%0d cmd=%h addr=%h len=%0d data=%h idx=%0d",
                     $realtime, what, want.kind, want.command, want.address,
                     want.payload_length, want.data_byte, want.byte_index);
            $display("    ok=%0d last=%0d pad=%h | got kind=%0d cmd=%h addr=%h len=%0d",
                     want.crc_ok, want.last, want.pad, got.kind, got.command,
                     got.address, got.payload_length);
            $display("    data=%h idx=%0d ok=%0d last=%0d pad=%h",
                     got.data_byte, got.byte_index, got.crc_ok, got.last, got.pad);
        end
    endtask

    // offer one byte, wait for it to be taken, then maybe open a gap
    task automatic push_byte(input logic [7:0] v, input bit fixed_exp,
                             input bit fixed_has, input rx_result_t fixed_res);
        rx_result_t r;
        bit         has;
        s_tdata  <= v;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        has = parse_rx_byte(v, r);
        if (fixed_exp) begin
            has = fixed_has;
            r   = fixed_res;
        end
        if (has) expected_q.push_back(r);
        bytes_accepted++;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(4, 12)) @(posedge aclk);
            else repeat ($urandom_range(1, 3)) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5)
                                                     : $urandom_range(20, 80);
        end else begin
            burst_left--;
        end
    endtask

    // well-formed frame with random content; cut_at >= 0 drops it early
    task automatic send_frame(input logic [7:0] len_byte, input bit crc_good,
                              input int cut_at);
        logic [15:0] crc;
        logic [7:0]  b;
        int          n_pay;
        int          pick;
        n_pay = (len_byte == 8'h00) ? 256 : len_byte;
        crc = ccfr_pkg::CRC_INIT;
        for (int pos = 0; pos < 5 + n_pay; pos++) begin
            pick = $urandom_range(0, 9);
            case (pos)
                0:       b = sync_value;
                1, 2, 3: b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
                4:       b = len_byte;
                default: b = (pick == 0) ? sync_value : 8'($urandom);
            endcase
            if (pos == cut_at) return;
            crc = crc16_step(crc, b);
            push_byte(b, 1'b0, 1'b0, NO_RES);
            frame_bytes++;
        end
        if (!crc_good) crc ^= 16'h0001 << $urandom_range(0, 15);
        push_byte(crc[15:8], 1'b0, 1'b0, NO_RES);
        push_byte(crc[7:0], 1'b0, 1'b0, NO_RES);
        frame_bytes += 2;
    endtask

    // result checker
    always @(posedge aclk) begin
        rx_result_t got;
        rx_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind           = m_tuser;
            got.command        = m_tdata[7:0];
            got.address        = m_tdata[23:8];
            got.payload_length = m_tdata[32:24];
            got.data_byte      = m_tdata[40:33];
            got.byte_index     = m_tdata[48:41];
            got.crc_ok         = m_tdata[49];
            got.pad            = m_tdata[55:50];
            got.last           = m_tlast;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected", NO_RES, got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) report_mismatch("result mismatch", want, got);
            end
        end
    end

    // receiver: stall patterns of its own, plus one long hold-off
    initial begin
        int ready_pct;
        bit held_off;
        held_off = 1'b0;
        forever begin
            if (!held_off && bytes_accepted > 500) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            case ($urandom_range(0, 3))
                0:       ready_pct = 100;
                1:       ready_pct = 50;
                2:       ready_pct = 85;
                default: ready_pct = 20;
            endcase
            repeat ($urandom_range(20, 200)) begin
                m_tready <= ($urandom_range(0, 99) < ready_pct);
                @(posedge aclk);
            end
        end
    end

    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        dir_row_t    row;
        logic [15:0] draft_crc;
        logic [7:0]  b;
        logic [7:0]  new_sync;
        int          target;
        int          pick;

        sync_value  = ccfr_pkg::SYNC_BYTE_RESET;
        frame_phase = ccfr_pkg::PH_HUNT;
        frame_crc   = 16'h0000;
        frame_cmd   = 8'h00;
        frame_addr  = 16'h0000;
        frame_len   = 9'd0;
        frame_count = 9'd0;
        crc_hi_byte = 8'h00;
        draft_crc   = ccfr_pkg::CRC_INIT;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 20; i++) begin
            row = DIRECTED_ROWS[i];
            case (row.kind)
                ROW_SYNC: begin
                    draft_crc = crc16_step(ccfr_pkg::CRC_INIT, row.value);
                    b = row.value;
                end
                ROW_FOLD: begin
                    draft_crc = crc16_step(draft_crc, row.value);
                    b = row.value;
                end
                ROW_CRC_HI: b = draft_crc[15:8];
                ROW_CRC_LO: b = draft_crc[7:0];
                default:    b = row.value;
            endcase
            push_byte(b, row.fixed_exp, row.fixed_has, row.res);
        end

        for (int setting_no = 0; setting_no < SETTING_COUNT; setting_no++) begin
            if (setting_no != 0) begin
                // sync is only changed once the result stream has drained
                s_tvalid <= 1'b0;
                while (expected_q.size() != 0) @(posedge aclk);
                repeat (IDLE_SETTLE) @(posedge aclk);
                new_sync = (setting_no == 1) ? 8'h00 :
                           (setting_no == 2) ? 8'hFF : 8'($urandom_range(1, 254));
                cfg_wr_data <= new_sync;
                cfg_wr_en   <= 1'b1;
                @(posedge aclk);
                cfg_wr_en   <= 1'b0;
                sync_value = new_sync;
            end
            // the longest frames, once each
            if (setting_no == 1) send_frame(8'h00, 1'b1, -1);
            if (setting_no == 3) send_frame(8'hFF, 1'($urandom_range(0, 1)), -1);
            target = frame_bytes + BYTES_PER_SET;
            while (frame_bytes < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    repeat ($urandom_range(1, 4)) begin
                        b = 8'($urandom);
                        if (b == sync_value) b ^= 8'h01;
                        push_byte(b, 1'b0, 1'b0, NO_RES);
                    end
                end else if (pick < 20) begin
                    send_frame(8'($urandom_range(1, 12)), 1'b1, $urandom_range(1, 8));
                end else if (pick < 30) begin
                    send_frame(8'($urandom_range(13, 64)), $urandom_range(0, 3) != 0, -1);
                end else begin
                    send_frame(8'($urandom_range(1, 12)), $urandom_range(0, 3) != 0, -1);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (END_SETTLE) @(posedge aclk);
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
